// ===== hw/rtl/ngst_pkg.sv =====
// Shared types and constants for the GSV satellite tracker.
`timescale 1ns / 1ps
package ngst_pkg;
	localparam int NGROUPS = 5;

	localparam logic [2:0] SYS_GPS     = 3'd0;
	localparam logic [2:0] SYS_GLONASS = 3'd1;
	localparam logic [2:0] SYS_BEIDOU  = 3'd2;
	localparam logic [2:0] SYS_QZSS    = 3'd3;
	localparam logic [2:0] SYS_GALILEO = 3'd4;
	localparam logic [2:0] SYS_MIXED   = 3'd5;
	localparam logic [2:0] SYS_UNKNOWN = 3'd6;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_V      = 8'h56;

	// One satellite update handed from the parser to the table engine.
	typedef struct packed {
		logic [2:0]  sys;
		logic [15:0] num;
		logic [15:0] elev;
		logic [15:0] azim;
		logic [15:0] snr;
		logic [31:0] now;
		logic        last;
	} ngst_job_t;

	function automatic logic [2:0] classify(input logic [15:0] talker, input logic [15:0] num);
		logic [7:0] a;
		logic [7:0] b;
		logic [2:0] r;
		begin
			a = talker[15:8];
			b = talker[7:0];
			r = SYS_UNKNOWN;
			if (a == 8'h47 && b == 8'h50)
				r = (num >= 16'd193 && num <= 16'd202) ? SYS_QZSS : SYS_GPS;
			else if (a == 8'h47 && b == 8'h4C) r = SYS_GLONASS;
			else if ((a == 8'h47 && b == 8'h42) || (a == 8'h42 && b == 8'h44)) r = SYS_BEIDOU;
			else if ((a == 8'h47 && b == 8'h51) || (a == 8'h51 && b == 8'h5A)) r = SYS_QZSS;
			else if (a == 8'h47 && b == 8'h41) r = SYS_GALILEO;
			else if (a == 8'h47 && b == 8'h4E) begin
				if (num >= 16'd1 && num <= 16'd32) r = SYS_GPS;
				else if (num >= 16'd65 && num <= 16'd96) r = SYS_GLONASS;
				else if (num >= 16'd193 && num <= 16'd200) r = SYS_QZSS;
				else if (num >= 16'd201 && num <= 16'd237) r = SYS_BEIDOU;
				else r = SYS_MIXED;
			end
			classify = r;
		end
	endfunction
endpackage

// ===== hw/rtl/ngst_parser.sv =====
// Byte parser: splits GSV sentences and emits one job per complete group.
`timescale 1ns / 1ps
module ngst_parser #(
	parameter int LINE_LIMIT  = 160,
	parameter int FIELD_LIMIT = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        byte_in,
	input  logic [31:0]       now_ms,
	output logic              job_valid,
	input  logic              job_stall,
	output ngst_pkg::ngst_job_t job
);
	import ngst_pkg::*;

	localparam int CW = $clog2(LINE_LIMIT + 1);
	localparam int FW = $clog2(FIELD_LIMIT + 1);

	logic          in_sent_q;
	logic [CW-1:0] cnt_q;
	logic [FW-1:0] fidx_q;
	logic [15:0]   talker_q;
	logic          hok_q;
	logic          star_q;
	logic [15:0]   acc_q;
	logic          nonempty_q, started_q, neg_q, stop_q;
	logic [2:0]    hlen_q;
	logic [15:0]   pv_q [NGROUPS][4];
	logic [NGROUPS-1:0] pok_q;

	// Commit drain after a line end: one group per cycle unless stalled.
	logic          drain_q;
	logic [2:0]    dg_q;
	logic [31:0]   dnow_q;
	logic [NGROUPS-1:0] dmask_q;

	assign in_stall = drain_q;
	logic acc;
	assign acc = in_valid && !drain_q;

	// Value of the field now being closed.
	logic [15:0] fval;
	logic [4:0]  fofs;
	logic        fin_ok;
	logic [2:0]  fg;
	logic [1:0]  fc;
	always_comb begin
		fofs = 5'(fidx_q - FW'(4));
		fg = 3'(fofs >> 2);
		fc = fofs[1:0];
		fin_ok = (fidx_q >= FW'(4)) && ((fidx_q - FW'(4)) < FW'(4 * NGROUPS));
		if (!nonempty_q) fval = (fc == 2'd0) ? 16'd0 : 16'hFFFF;
		else if (neg_q) fval = 16'(16'd0 - acc_q);
		else fval = acc_q;
	end

	// Remaining committable groups after the current one.
	logic [NGROUPS-1:0] rest;
	logic [NGROUPS-1:0] emask;
	always_comb begin
		for (int g = 0; g < NGROUPS; g++)
			emask[g] = pok_q[g] && (pv_q[g][0] != 16'd0);
		rest = '0;
		for (int g = 0; g < NGROUPS; g++)
			rest[g] = dmask_q[g] && (3'(g) > dg_q);
	end

	logic emit;
	assign emit = drain_q && dmask_q[dg_q] && !(job_valid && job_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0; cnt_q <= '0; fidx_q <= '0; talker_q <= '0;
			hok_q <= 1'b0; star_q <= 1'b0; acc_q <= '0;
			nonempty_q <= 1'b0; started_q <= 1'b0; neg_q <= 1'b0; stop_q <= 1'b0;
			hlen_q <= '0; pok_q <= '0; drain_q <= 1'b0; dg_q <= '0; dmask_q <= '0;
			job_valid <= 1'b0;
		end else begin
			if (job_valid && !job_stall && !emit) job_valid <= 1'b0;
			if (drain_q) begin
				if (!dmask_q[dg_q]) begin
					if (dg_q == 3'(NGROUPS - 1)) drain_q <= 1'b0;
					else dg_q <= dg_q + 3'd1;
				end else if (emit) begin
					job_valid <= 1'b1;
					job.sys  <= classify(talker_q, pv_q[dg_q][0]);
					job.num  <= pv_q[dg_q][0];
					job.elev <= pv_q[dg_q][1];
					job.azim <= pv_q[dg_q][2];
					job.snr  <= pv_q[dg_q][3];
					job.now  <= dnow_q;
					job.last <= (rest == '0);
					if (dg_q == 3'(NGROUPS - 1) || rest == '0) drain_q <= 1'b0;
					else dg_q <= dg_q + 3'd1;
				end
			end else if (acc) begin
				if (byte_in == CH_DOLLAR) begin
					in_sent_q <= 1'b1; cnt_q <= CW'(1); fidx_q <= '0; talker_q <= '0;
					hok_q <= 1'b1; star_q <= 1'b0; acc_q <= '0;
					nonempty_q <= 1'b0; started_q <= 1'b0; neg_q <= 1'b0; stop_q <= 1'b0;
					hlen_q <= '0; pok_q <= '0;
				end else if (in_sent_q) begin
					if (byte_in == CH_CR || byte_in == CH_LF) begin
						in_sent_q <= 1'b0;
						cnt_q <= '0;
						begin : line_end
							logic [NGROUPS-1:0] m;
							m = emask;
							if (!star_q && fin_ok && fc == 2'd3 && (fg != 3'd0 ? 1'b1 : 1'b1))
								m[fg] = (pv_q[fg][0] != 16'd0);
							if (!star_q && fin_ok && fc == 2'd0)
								m[fg] = 1'b0;
							if (!star_q && fin_ok) begin
								pv_q[fg][fc] <= fval;
								if (fc == 2'd3) pok_q[fg] <= 1'b1;
							end
							if (hok_q && hlen_q == 3'd5 && (32'(fidx_q) + 32'd1 >= 32'd8)
								&& m != '0) begin
								drain_q <= 1'b1;
								dg_q <= '0;
								dmask_q <= m;
								dnow_q <= now_ms;
							end
						end
					end else if (32'(cnt_q) >= 32'(LINE_LIMIT - 1)) begin
						in_sent_q <= 1'b0;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						if (!star_q) begin
							if (byte_in == CH_STAR || byte_in == CH_NUL) begin
								star_q <= 1'b1;
								if (fin_ok) begin
									pv_q[fg][fc] <= fval;
									if (fc == 2'd3) pok_q[fg] <= 1'b1;
								end
							end else if (byte_in == CH_COMMA &&
								(32'(fidx_q) + 32'd1 < 32'(FIELD_LIMIT))) begin
								if (fin_ok) begin
									pv_q[fg][fc] <= fval;
									if (fc == 2'd3) pok_q[fg] <= 1'b1;
								end
								fidx_q <= fidx_q + FW'(1);
								acc_q <= '0;
								nonempty_q <= 1'b0; started_q <= 1'b0;
								neg_q <= 1'b0; stop_q <= 1'b0;
							end else if (fidx_q == '0) begin
								if (hlen_q == 3'd0) talker_q[15:8] <= byte_in;
								else if (hlen_q == 3'd1) talker_q[7:0] <= byte_in;
								else if (hlen_q == 3'd2) begin
									if (byte_in != CH_G) hok_q <= 1'b0;
								end else if (hlen_q == 3'd3) begin
									if (byte_in != CH_S) hok_q <= 1'b0;
								end else if (hlen_q == 3'd4) begin
									if (byte_in != CH_V) hok_q <= 1'b0;
								end else hok_q <= 1'b0;
								if (hlen_q < 3'd6) hlen_q <= hlen_q + 3'd1;
							end else if (fidx_q >= FW'(4)) begin
								nonempty_q <= 1'b1;
								if (!stop_q) begin
									if (!started_q && (byte_in == CH_SPACE || byte_in == CH_TAB ||
										byte_in == CH_VT || byte_in == CH_FF)) begin
									end else if (!started_q &&
										(byte_in == CH_PLUS || byte_in == CH_MINUS)) begin
										started_q <= 1'b1;
										if (byte_in == CH_MINUS) neg_q <= 1'b1;
									end else if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
										started_q <= 1'b1;
										acc_q <= 16'((acc_q << 3) + (acc_q << 1)
											+ {8'd0, byte_in - 8'h30});
									end else stop_q <= 1'b1;
								end
							end
						end
					end
				end
			end
		end
	end
endmodule

// ===== hw/rtl/ngst_queue.sv =====
// Two-entry job queue between the parser and the table engine.
`timescale 1ns / 1ps
module ngst_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_stall,
	input  ngst_pkg::ngst_job_t wr_job,
	output logic              rd_valid,
	input  logic              rd_stall,
	output ngst_pkg::ngst_job_t rd_job
);
	import ngst_pkg::*;

	ngst_job_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

// ===== hw/rtl/ngst_table.sv =====
// Table engine: scans the satellite table and places one update per job.
`timescale 1ns / 1ps
module ngst_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_stall,
	input  ngst_pkg::ngst_job_t job,
	output logic              valid,
	input  logic              stall,
	output logic [5:0]        slot,
	output logic [2:0]        system_code,
	output logic [15:0]       sat_id,
	output logic signed [15:0] elev_deg,
	output logic signed [15:0] azim_deg,
	output logic signed [15:0] snr_dbhz,
	output logic              newly_placed,
	output logic              evicted,
	output logic              last_of_run
);
	import ngst_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	// Key and timestamp memories; occupancy in flip-flops.
	logic [18:0] key_mem [TABLE_DEPTH];
	logic [31:0] seen_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] occ_q;

	typedef enum logic [1:0] {IDLE, SCAN, DONE, WRITE} st_t;
	st_t st_q;
	ngst_job_t cur_q;
	logic [AW:0]   idx_q;   // address issued
	logic [AW-1:0] ridx_q;  // address of registered read data
	logic          rv_q;
	logic [18:0]   rkey_q;
	logic [31:0]   rseen_q;
	logic          found_q, hasempty_q;
	logic [AW-1:0] fidx_q, eidx_q, oidx_q;
	logic [31:0]   oseen_q;
	logic [AW-1:0] tgt_q;
	logic          fresh_q, ev_q;
	logic          wr_fire;

	assign job_stall = (st_q != IDLE);
	assign wr_fire = (st_q == WRITE) && !(valid && stall);

	always_ff @(posedge clk) begin
		if (st_q == SCAN && !idx_q[AW]) begin
			rkey_q  <= key_mem[idx_q[AW-1:0]];
			rseen_q <= seen_mem[idx_q[AW-1:0]];
		end
		if (st_q == WRITE) begin
			key_mem[tgt_q]  <= {cur_q.sys, cur_q.num};
			seen_mem[tgt_q] <= cur_q.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE; valid <= 1'b0; occ_q <= '0; rv_q <= 1'b0; idx_q <= '0;
		end else begin
			if (valid && !stall && !wr_fire) valid <= 1'b0;
			unique case (st_q)
				IDLE: if (job_valid) begin
					cur_q <= job; idx_q <= '0; rv_q <= 1'b0;
					found_q <= 1'b0; hasempty_q <= 1'b0; oidx_q <= '0;
					st_q <= SCAN;
				end
				SCAN: begin
					if (!idx_q[AW]) begin
						idx_q <= idx_q + (AW+1)'(1);
						ridx_q <= idx_q[AW-1:0];
					end
					rv_q <= !idx_q[AW];
					if (rv_q && !found_q) begin
						// Entry 0 seeds the oldest timestamp.
						if (ridx_q == '0 || rseen_q < oseen_q) begin
							oseen_q <= rseen_q; oidx_q <= ridx_q;
						end
						if (occ_q[ridx_q] && rkey_q == {cur_q.sys, cur_q.num}) begin
							found_q <= 1'b1; fidx_q <= ridx_q;
						end else if (!occ_q[ridx_q] && !hasempty_q) begin
							hasempty_q <= 1'b1; eidx_q <= ridx_q;
						end
					end
					if (idx_q[AW] && !rv_q) st_q <= DONE;
				end
				DONE: begin
					if (found_q) begin
						tgt_q <= fidx_q; fresh_q <= 1'b0; ev_q <= 1'b0;
					end else if (hasempty_q) begin
						tgt_q <= eidx_q; fresh_q <= 1'b1; ev_q <= 1'b0;
					end else begin
						tgt_q <= oidx_q; fresh_q <= 1'b1; ev_q <= occ_q[oidx_q];
					end
					st_q <= WRITE;
				end
				WRITE: if (wr_fire) begin
					occ_q[tgt_q] <= 1'b1;
					valid <= 1'b1;
					slot <= 6'(tgt_q);
					system_code <= cur_q.sys;
					sat_id <= cur_q.num;
					elev_deg <= cur_q.elev;
					azim_deg <= cur_q.azim;
					snr_dbhz <= cur_q.snr;
					newly_placed <= fresh_q;
					evicted <= ev_q;
					last_of_run <= cur_q.last;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/nmea_gsv_satellite_tracker_unit.sv =====
// Top level of the GSV satellite tracker: parser, job queue and table engine.
// Each byte that causes no update is taken without a stall; a line end drains
// one group per cycle into the queue while it is not full, and stalls the
// input until done. Each table update is a serial scan of the single-port
// key and timestamp memories and a write; no new job is taken before the write.
// Reset clears the state machines, pointers and valid flags and marks every table entry unoccupied.
`timescale 1ns / 1ps
module nmea_gsv_satellite_tracker_unit #(
	parameter int TABLE_DEPTH = 64,
	parameter int LINE_LIMIT  = 160,
	parameter int FIELD_LIMIT = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        byte_in,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [5:0]        slot,
	output logic [2:0]        system_code,
	output logic [15:0]       sat_id,
	output logic signed [15:0] elev_deg,
	output logic signed [15:0] azim_deg,
	output logic signed [15:0] snr_dbhz,
	output logic              newly_placed,
	output logic              evicted,
	output logic              last_of_run
);
	import ngst_pkg::*;

	logic      pj_valid, pj_stall, qj_valid, qj_stall;
	ngst_job_t pj, qj;

	ngst_parser #(.LINE_LIMIT(LINE_LIMIT), .FIELD_LIMIT(FIELD_LIMIT)) u_parser (
		.clk, .arst_n, .in_valid, .in_stall, .byte_in, .now_ms,
		.job_valid(pj_valid), .job_stall(pj_stall), .job(pj));

	ngst_queue u_queue (
		.clk, .arst_n, .wr_valid(pj_valid), .wr_stall(pj_stall), .wr_job(pj),
		.rd_valid(qj_valid), .rd_stall(qj_stall), .rd_job(qj));

	ngst_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
		.clk, .arst_n, .job_valid(qj_valid), .job_stall(qj_stall), .job(qj),
		.valid(out_valid), .stall(out_stall), .slot, .system_code, .sat_id,
		.elev_deg, .azim_deg, .snr_dbhz, .newly_placed, .evicted, .last_of_run);

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> system_code <= SYS_UNKNOWN)
		else $error("bad system code");
	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> newly_placed)
		else $error("eviction without placement");
endmodule
